@@ design/spat_pkg.sv @@
// ---------------------------------------------------------------------------
// spat_pkg: shared types and constants of the segment/page translator
// Function and fault codes, payload words and the request structs that pass
// from the top level into the descriptor and paging stages and between them.
// ---------------------------------------------------------------------------
`default_nettype none

package spat_pkg;

    localparam int unsigned DESC_ENTRIES = 256;
    localparam int unsigned DESC_IDX_W   = $clog2(DESC_ENTRIES);
    localparam int unsigned DESC_AW      = DESC_IDX_W + 1;   // table indicator on top
    localparam int unsigned PG_AW        = 10;
    localparam int unsigned SEL_IDX_W    = 13;

    localparam logic [2:0] FN_WR_GDT = 3'd0;
    localparam logic [2:0] FN_WR_LDT = 3'd1;
    localparam logic [2:0] FN_WR_DIR = 3'd2;
    localparam logic [2:0] FN_WR_PG  = 3'd3;
    localparam logic [2:0] FN_XLATE  = 3'd4;

    localparam logic [2:0] FLT_OK     = 3'd0;
    localparam logic [2:0] FLT_NULL   = 3'd1;
    localparam logic [2:0] FLT_RANGE  = 3'd2;
    localparam logic [2:0] FLT_SEG    = 3'd3;
    localparam logic [2:0] FLT_DIR    = 3'd4;
    localparam logic [2:0] FLT_PAGE   = 3'd5;

    typedef logic [DESC_AW-1:0] t_desc_addr;

    typedef struct packed {
        logic [2:0]  func;
        logic [9:0]  entry_index;
        logic [63:0] entry_data;
        logic [15:0] segment_selector;
        logic [31:0] offset_in;
    } t_in;

    typedef struct packed {
        logic [31:0] physical_address;
        logic [2:0]  fault;
    } t_out;

    typedef struct packed {
        logic        en;
        t_desc_addr  addr;
        logic [63:0] data;
    } t_desc_wr;

    typedef struct packed {
        logic        en;
        t_desc_addr  addr;
        logic [31:0] ofs;
        logic [2:0]  flt;
    } t_desc_rd;

    typedef struct packed {
        logic [31:0] lin;
        logic [2:0]  flt;
    } t_lin;

    typedef struct packed {
        logic             dir_en;
        logic             pg_en;
        logic [PG_AW-1:0] addr;
        logic [31:0]      data;
    } t_pg_wr;

endpackage

`default_nettype wire

@@ design/segment_page_address_translator.sv @@
// ---------------------------------------------------------------------------
// segment_page_address_translator: segmentation plus one-level page lookup
// Translates pass the descriptor read register, then the page read register.
// Throughput: one word per cycle unless the output stalls; table writes and
// translates mix freely. The rate is set by the descriptor memory read, then the
// parallel directory and page table reads, each one registered port per cycle.
// Reset clears pipeline valids only; table contents stay undefined until written.
// ---------------------------------------------------------------------------
`default_nettype none

module segment_page_address_translator
    import spat_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    logic                 r_s1_vld, n_s1_vld;
    logic                 r_s2_vld, n_s2_vld;
    logic                 w_acc, w_s1_adv, w_s2_adv, w_is_xl;
    logic                 w_ldt;
    logic [SEL_IDX_W-1:0] w_sel_idx;
    logic [2:0]           w_early_flt;
    t_desc_wr             w_desc_wr;
    t_desc_rd             w_desc_rd;
    t_pg_wr               w_pg_wr;
    t_lin                 w_lin;

    assign w_s2_adv    = !r_s2_vld || i_out_ready;
    assign w_s1_adv    = !r_s1_vld || w_s2_adv;
    assign o_in_ready  = w_s1_adv;
    assign w_acc       = i_in_valid && o_in_ready;
    assign w_is_xl     = (i_in_data.func == FN_XLATE);
    assign w_ldt       = i_in_data.segment_selector[2];
    assign w_sel_idx   = i_in_data.segment_selector[15:3];
    assign o_out_valid = r_s2_vld;

    always_comb begin
        if (!w_ldt && (w_sel_idx == '0)) begin
            w_early_flt = FLT_NULL;
        end else if (32'(w_sel_idx) >= DESC_ENTRIES) begin
            w_early_flt = FLT_RANGE;
        end else begin
            w_early_flt = FLT_OK;
        end
    end

    always_comb begin
        // drop descriptor writes beyond the store
        w_desc_wr.en   = w_acc && ((i_in_data.func == FN_WR_GDT) ||
                                   (i_in_data.func == FN_WR_LDT)) &&
                         (32'(i_in_data.entry_index) < DESC_ENTRIES);
        w_desc_wr.addr = {(i_in_data.func == FN_WR_LDT),
                          DESC_IDX_W'(i_in_data.entry_index)};
        w_desc_wr.data = i_in_data.entry_data;

        w_desc_rd.en   = w_acc && w_is_xl;
        w_desc_rd.addr = {w_ldt, w_sel_idx[DESC_IDX_W-1:0]};
        w_desc_rd.ofs  = i_in_data.offset_in;
        w_desc_rd.flt  = w_early_flt;

        w_pg_wr.dir_en = w_acc && (i_in_data.func == FN_WR_DIR);
        w_pg_wr.pg_en  = w_acc && (i_in_data.func == FN_WR_PG);
        w_pg_wr.addr   = i_in_data.entry_index;
        w_pg_wr.data   = i_in_data.entry_data[31:0];
    end

    always_comb begin
        n_s1_vld = w_s1_adv ? w_desc_rd.en : r_s1_vld;
        n_s2_vld = w_s2_adv ? r_s1_vld : r_s2_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
            r_s2_vld <= n_s2_vld;
        end
    end

    spat_desc_stage u_desc (
        .i_clk (i_clk),
        .i_wr  (w_desc_wr),
        .i_rd  (w_desc_rd),
        .o_lin (w_lin)
    );

    spat_page_stage u_page (
        .i_clk   (i_clk),
        .i_wr    (w_pg_wr),
        .i_rd_en (r_s1_vld && w_s1_adv),
        .i_lin   (w_lin),
        .o_res   (o_out_data)
    );

    a_xl_enters_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_is_xl) |=> r_s1_vld)
        else $error("accepted translate word did not enter stage one");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !w_s1_adv) |=> r_s1_vld)
        else $error("stalled stage one word was lost");

    a_s1_to_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && w_s1_adv) |=> r_s2_vld)
        else $error("stage one word did not reach the output");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.fault != FLT_OK)) |->
            (o_out_data.physical_address == '0))
        else $error("faulted result carries a nonzero address");

endmodule

`default_nettype wire

@@ design/spat_desc_stage.sv @@
// ---------------------------------------------------------------------------
// spat_desc_stage: descriptor memory and linear address stage
// Holds GDT and LDT in one synchronous memory, addressed by table indicator
// and index. Produces the linear address and the segment fault combinationally
// from the registered read, in the cycle after the read is issued.
// ---------------------------------------------------------------------------
`default_nettype none

module spat_desc_stage
    import spat_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_desc_wr i_wr,
    input  wire t_desc_rd i_rd,
    output t_lin          o_lin
);

    localparam int unsigned DESC_SLOTS = 2 << DESC_IDX_W;

    // keep base 31:24, base 23:0 and the present bit only
    logic [32:0] r_mem [DESC_SLOTS];
    logic [32:0] r_desc;
    logic [31:0] r_ofs;
    logic [2:0]  r_flt;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= {i_wr.data[63:56], i_wr.data[39:16], i_wr.data[47]};
        end
        if (i_rd.en) begin
            r_desc <= r_mem[i_rd.addr];
            r_ofs  <= i_rd.ofs;
            r_flt  <= i_rd.flt;
        end
    end

    always_comb begin
        o_lin.lin = r_desc[32:1] + r_ofs;
        if (r_flt != FLT_OK) begin
            o_lin.flt = r_flt;
        end else if (!r_desc[0]) begin
            o_lin.flt = FLT_SEG;
        end else begin
            o_lin.flt = FLT_OK;
        end
    end

endmodule

`default_nettype wire

@@ design/spat_page_stage.sv @@
// ---------------------------------------------------------------------------
// spat_page_stage: page directory and page table lookup
// Reads the directory present bit and the page entry in parallel from two
// synchronous memories and forms the physical address and final fault.
// ---------------------------------------------------------------------------
`default_nettype none

module spat_page_stage
    import spat_pkg::*;
(
    input  wire logic   i_clk,
    input  wire t_pg_wr i_wr,
    input  wire logic   i_rd_en,
    input  wire t_lin   i_lin,
    output t_out        o_res
);

    localparam int unsigned PG_SLOTS = 1 << PG_AW;

    logic        r_dir [PG_SLOTS];      // directory present bits
    logic [20:0] r_pg  [PG_SLOTS];      // frame and present bit
    logic        r_pde_p;
    logic [20:0] r_pte;
    logic [11:0] r_lo;
    logic [2:0]  r_flt;

    always_ff @(posedge i_clk) begin
        if (i_wr.dir_en) begin
            r_dir[i_wr.addr] <= i_wr.data[0];
        end
        if (i_wr.pg_en) begin
            r_pg[i_wr.addr] <= {i_wr.data[31:12], i_wr.data[0]};
        end
        // read before write on the same edge keeps program order
        if (i_rd_en) begin
            r_pde_p <= r_dir[i_lin.lin[31:22]];
            r_pte   <= r_pg[i_lin.lin[21:12]];
            r_lo    <= i_lin.lin[11:0];
            r_flt   <= i_lin.flt;
        end
    end

    always_comb begin
        o_res.physical_address = '0;
        if (r_flt != FLT_OK) begin
            o_res.fault = r_flt;
        end else if (!r_pde_p) begin
            o_res.fault = FLT_DIR;
        end else if (!r_pte[0]) begin
            o_res.fault = FLT_PAGE;
        end else begin
            o_res.fault            = FLT_OK;
            o_res.physical_address = {r_pte[20:1], r_lo};
        end
    end

endmodule

`default_nettype wire
